/* src/gbts_pkg.sv */
// Shared types and constants for the gap buffer text store.
// No dependencies; gbts_cell, gbts_ctrl and the core import this package.
`default_nettype none
package gbts_pkg;

	localparam int OP_W   = 3;
	localparam int CHAR_W = 8;
	localparam int ST_W   = 2;

	// Editing request codes
	typedef enum logic [OP_W-1:0] {
		OP_INSERT    = 3'd0,
		OP_DELETE    = 3'd1,
		OP_BACKSPACE = 3'd2,
		OP_MOVE      = 3'd3,
		OP_REPLACE   = 3'd4
	} op_t;

	// Response status codes
	typedef enum logic [ST_W-1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_BEYOND = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	// What every cell of the ring does at the next edge
	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_ROT_LEFT,
		CELL_ROT_RIGHT,
		CELL_INSERT,
		CELL_DELETE,
		CELL_BACKSPACE,
		CELL_REPLACE
	} cell_op_t;

	typedef struct packed {
		cell_op_t            op;
		logic [CHAR_W-1:0]   ch;
		logic [CHAR_W-1:0]   rep;
	} cell_cmd_t;

	// Sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_MOVE,
		S_DONE
	} state_t;

endpackage
`default_nettype wire

/* src/gbts_if.sv */
// Request and response channel interfaces of the gap buffer text store.
// Depends on nothing; widths of the counts follow the CW parameter.
`default_nettype none
interface gbts_req_if #(parameter int CW = 9);
	logic          valid;
	logic          ready;
	logic [2:0]    operation;
	logic [7:0]    character;
	logic [7:0]    replacement;
	logic [CW-1:0] position;

	modport source(output valid, output operation, output character, output replacement,
		output position, input ready);
	modport sink(input valid, input operation, input character, input replacement,
		input position, output ready);
endinterface

interface gbts_rsp_if #(parameter int CW = 9);
	logic          valid;
	logic          ready;
	logic [1:0]    status;
	logic [7:0]    char_before_cursor;
	logic [CW-1:0] count_before_cursor;
	logic [7:0]    char_after_cursor;
	logic [CW-1:0] count_after_cursor;

	modport source(output valid, output status, output char_before_cursor,
		output count_before_cursor, output char_after_cursor, output count_after_cursor,
		input ready);
	modport sink(input valid, input status, input char_before_cursor,
		input count_before_cursor, input char_after_cursor, input count_after_cursor,
		output ready);
endinterface
`default_nettype wire

/* src/gbts_cell.sv */
// One character cell of the text ring: holds a character and takes it from a
// neighbour, the insert feed or the replacement as the command says. Uses gbts_pkg.
`default_nettype none
module gbts_cell #(
	parameter int CAPACITY = 256,
	parameter int INDEX    = 0,
	localparam int CW      = $clog2(CAPACITY + 1)
) (
	input  wire logic                   clk,
	input  wire gbts_pkg::cell_cmd_t    cmd,
	input  wire logic [CW-1:0]          before_count,
	input  wire logic [CW-1:0]          after_count,
	input  wire logic [7:0]             prev_data,
	input  wire logic [7:0]             next_data,
	output logic [7:0]                  data
);
	import gbts_pkg::*;

	localparam logic [CW:0] IDX = (CW + 1)'(INDEX);
	localparam logic [CW:0] CAP = (CW + 1)'(CAPACITY);

	logic       in_after;
	logic       in_before;
	logic [7:0] data_q;
	logic [7:0] data_d;

	// After text fills cells 0 upward, before text ends at the last cell
	assign in_after  = IDX < {1'b0, after_count};
	assign in_before = (IDX + {1'b0, before_count}) >= CAP;

	// Pick the next value of this cell
	always_comb begin
		data_d = data_q;
		case (cmd.op)
			CELL_HOLD:      data_d = data_q;
			CELL_ROT_LEFT:  data_d = next_data;
			CELL_ROT_RIGHT: data_d = prev_data;
			CELL_INSERT:    if (!in_after) data_d = next_data;
			CELL_DELETE:    if (in_after) data_d = next_data;
			CELL_BACKSPACE: if (in_before) data_d = prev_data;
			CELL_REPLACE:   if (data_q == cmd.ch) data_d = cmd.rep;
			default:        data_d = data_q;
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;

endmodule
`default_nettype wire

/* src/gbts_ctrl.sv */
// Sequencer of the gap buffer text store: takes requests, keeps both stack sizes,
// steps cursor moves and registers the response. Uses gbts_pkg and gbts_if.
`default_nettype none
module gbts_ctrl #(
	parameter int CAPACITY = 256,
	localparam int CW      = $clog2(CAPACITY + 1)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	gbts_req_if.sink                 req,
	gbts_rsp_if.source               rsp,
	output gbts_pkg::cell_cmd_t      cmd,
	output logic [CW-1:0]            before_count,
	output logic [CW-1:0]            after_count,
	input  wire logic [7:0]          top_before,
	input  wire logic [7:0]          top_after
);
	import gbts_pkg::*;

	localparam logic [CW:0] CAP = (CW + 1)'(CAPACITY);

	state_t        state_q, state_d;
	logic [CW-1:0] b_q, b_d;
	logic [CW-1:0] a_q, a_d;
	logic [CW-1:0] target_q, target_d;
	status_t       pend_q, pend_d;
	logic          rsp_valid_q, rsp_valid_d;
	logic          rsp_load;
	status_t       rsp_status_q;
	logic [7:0]    rsp_cb_q, rsp_ca_q;
	logic [CW-1:0] rsp_nb_q, rsp_na_q;
	logic          accept;
	logic [CW:0]   total;

	// Take a request only while idle
	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign total     = {1'b0, b_q} + {1'b0, a_q};

	// Next state, counts and the ring command
	always_comb begin
		state_d     = state_q;
		b_d         = b_q;
		a_d         = a_q;
		target_d    = target_q;
		pend_d      = pend_q;
		rsp_load    = 1'b0;
		cmd.op      = CELL_HOLD;
		cmd.ch      = req.character;
		cmd.rep     = req.replacement;
		rsp_valid_d = rsp_valid_q && !rsp.ready;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_DONE;
					pend_d  = ST_OK;
					case (op_t'(req.operation))
						OP_INSERT: begin
							if (total >= CAP) begin
								pend_d = ST_FULL;
							end else begin
								cmd.op = CELL_INSERT;
								b_d    = b_q + 1'b1;
							end
						end
						OP_DELETE: begin
							if (a_q == '0) begin
								pend_d = ST_EMPTY;
							end else begin
								cmd.op = CELL_DELETE;
								a_d    = a_q - 1'b1;
							end
						end
						OP_BACKSPACE: begin
							if (b_q == '0) begin
								pend_d = ST_EMPTY;
							end else begin
								cmd.op = CELL_BACKSPACE;
								b_d    = b_q - 1'b1;
							end
						end
						OP_MOVE: begin
							if ({1'b0, req.position} > total) begin
								pend_d = ST_BEYOND;
							end else begin
								target_d = req.position;
								state_d  = S_MOVE;
							end
						end
						OP_REPLACE: cmd.op = CELL_REPLACE;
						default:    cmd.op = CELL_HOLD;
					endcase
				end
			end
			S_MOVE: begin
				// Rotate the ring one place per cycle towards the target
				if (b_q > target_q) begin
					cmd.op = CELL_ROT_RIGHT;
					b_d    = b_q - 1'b1;
					a_d    = a_q + 1'b1;
				end else if (b_q < target_q) begin
					cmd.op = CELL_ROT_LEFT;
					b_d    = b_q + 1'b1;
					a_d    = a_q - 1'b1;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				// Hand over once the response register is free
				if (!rsp_valid_q || rsp.ready) begin
					rsp_load    = 1'b1;
					rsp_valid_d = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			b_q         <= '0;
			a_q         <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			b_q         <= b_d;
			a_q         <= a_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		target_q <= target_d;
		pend_q   <= pend_d;
		if (rsp_load) begin
			rsp_status_q <= pend_q;
			rsp_cb_q     <= (b_q == '0) ? 8'd0 : top_before;
			rsp_nb_q     <= b_q;
			rsp_ca_q     <= (a_q == '0) ? 8'd0 : top_after;
			rsp_na_q     <= a_q;
		end
	end

	assign rsp.valid               = rsp_valid_q;
	assign rsp.status              = rsp_status_q;
	assign rsp.char_before_cursor  = rsp_cb_q;
	assign rsp.count_before_cursor = rsp_nb_q;
	assign rsp.char_after_cursor   = rsp_ca_q;
	assign rsp.count_after_cursor  = rsp_na_q;
	assign before_count            = b_q;
	assign after_count             = a_q;

	// Text never exceeds the store
	assert property (@(posedge clk) disable iff (!arst_n) total <= CAP)
		else $error("gbts: text longer than capacity");

	// A cursor step keeps the text length
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MOVE && b_q != target_q) |=> (total == $past(total)))
		else $error("gbts: cursor step changed text length");

	// A left step lowers the before count by one
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MOVE && b_q > target_q) |=> (b_q == $past(b_q) - 1'b1))
		else $error("gbts: left step miscounted");

	// An accepted insert lands at the top of the before stack
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op_t'(req.operation) == OP_INSERT && total < CAP)
		|=> (top_before == $past(req.character)))
		else $error("gbts: inserted character not at cursor");

endmodule
`default_nettype wire

/* src/gap_buffer_text_store_core.sv */
// Gap buffer text store: a ring of CAPACITY character cells holding the text
// around a cursor that always sits between the last cell and cell 0. Insert,
// delete, backspace, replace-all and rejected requests go straight to the done
// state and its response register; a cursor move first rotates the ring one
// place per cycle until count_before_cursor equals position. A new request is taken
// while the previous response waits. Depends on gbts_pkg, gbts_if, gbts_cell
// and gbts_ctrl.
`default_nettype none
module gap_buffer_text_store_core #(
	parameter int CAPACITY = 256,
	localparam int CW      = $clog2(CAPACITY + 1)
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	gbts_req_if.sink     req,
	gbts_rsp_if.source   rsp
);
	import gbts_pkg::*;

	cell_cmd_t     cmd;
	logic [CW-1:0] before_count;
	logic [CW-1:0] after_count;
	logic [7:0]    cell_data [CAPACITY];

	// Ring of character cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		localparam int PREV = (i + CAPACITY - 1) % CAPACITY;
		logic [7:0] next_data;

		if (i == CAPACITY - 1) begin : g_last
			// Feed the inserted character into the cell at the cursor
			assign next_data = (cmd.op == CELL_INSERT) ? cmd.ch : cell_data[0];
		end else begin : g_mid
			assign next_data = cell_data[i + 1];
		end

		gbts_cell #(
			.CAPACITY (CAPACITY),
			.INDEX    (i)
		) u_cell (
			.clk          (clk),
			.cmd          (cmd),
			.before_count (before_count),
			.after_count  (after_count),
			.prev_data    (cell_data[PREV]),
			.next_data    (next_data),
			.data         (cell_data[i])
		);
	end

	gbts_ctrl #(
		.CAPACITY (CAPACITY)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req),
		.rsp          (rsp),
		.cmd          (cmd),
		.before_count (before_count),
		.after_count  (after_count),
		.top_before   (cell_data[CAPACITY-1]),
		.top_after    (cell_data[0])
	);

endmodule
`default_nettype wire

/* test/gap_buffer_text_store_core_tb.sv */
// Self-checking testbench for the gap buffer text store core.
// Depends on gbts_pkg, gbts_if and the core; models the text and cursor itself
// and checks every response against that model, field by field.
`timescale 1ns / 1ps
`default_nettype none
module gap_buffer_text_store_core_tb;
	import gbts_pkg::*;

	localparam int STORE_CAP = 256;
	localparam int CNT_W     = $clog2(STORE_CAP + 1);
	localparam int POS_MAX   = (1 << CNT_W) - 1;
	// Codes with no editing meaning; the core answers them with no change
	localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;
	// Longest cursor move plus margin, waited out once at the end
	localparam int DRAIN_CYCLES = STORE_CAP + 64;

	typedef struct packed {
		status_t           status;
		logic [CHAR_W-1:0] ch_before;
		logic [CNT_W-1:0]  n_before;
		logic [CHAR_W-1:0] ch_after;
		logic [CNT_W-1:0]  n_after;
	} cursor_view_t;

	logic clk;
	logic arst_n;

	gbts_req_if #(.CW(CNT_W)) req_ch ();
	gbts_rsp_if #(.CW(CNT_W)) rsp_ch ();

	gap_buffer_text_store_core #(.CAPACITY(STORE_CAP)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Predicted text: before-cursor stack grows up from 0, after-cursor stack down from the top
	logic [CHAR_W-1:0] text_store [STORE_CAP];
	int                n_before;
	int                n_after;

	cursor_view_t      pending_views [$];
	bit                steady_flow;
	int                fail_count;
	int                requests_sent;
	int                status_seen [4];
	int                longest_text;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Apply one editing request to the predicted text and return the view it leaves
	function automatic cursor_view_t apply_edit(input logic [OP_W-1:0] op,
			input logic [CHAR_W-1:0] ch, input logic [CHAR_W-1:0] rep,
			input logic [CNT_W-1:0] pos);
		cursor_view_t view;
		int           target;
		view.status = ST_OK;
		target = int'(pos);
		case (op)
			OP_INSERT: begin
				if (n_before + n_after >= STORE_CAP) begin
					view.status = ST_FULL;
				end else begin
					text_store[n_before] = ch;
					n_before++;
				end
			end
			OP_DELETE: begin
				if (n_after == 0) view.status = ST_EMPTY;
				else n_after--;
			end
			OP_BACKSPACE: begin
				if (n_before == 0) view.status = ST_EMPTY;
				else n_before--;
			end
			OP_MOVE: begin
				if (target < n_before) begin
					while (n_before > target) begin
						text_store[STORE_CAP - 1 - n_after] = text_store[n_before - 1];
						n_after++;
						n_before--;
					end
				end else if (target - n_before > n_after) begin
					view.status = ST_BEYOND;
				end else begin
					while (n_before < target && n_after > 0) begin
						text_store[n_before] = text_store[STORE_CAP - n_after];
						n_after--;
						n_before++;
					end
				end
			end
			OP_REPLACE: begin
				for (int i = 0; i < n_before; i++)
					if (text_store[i] == ch) text_store[i] = rep;
				for (int i = 0; i < n_after; i++)
					if (text_store[STORE_CAP - 1 - i] == ch) text_store[STORE_CAP - 1 - i] = rep;
			end
			default: begin
			end
		endcase
		view.n_before  = CNT_W'(n_before);
		view.n_after   = CNT_W'(n_after);
		view.ch_before = (n_before != 0) ? text_store[n_before - 1] : '0;
		view.ch_after  = (n_after != 0) ? text_store[STORE_CAP - n_after] : '0;
		return view;
	endfunction

	// Pick a character that occurs in the text, so that replace finds something
	function automatic logic [CHAR_W-1:0] pick_text_char();
		int idx;
		idx = $urandom_range(n_before + n_after - 1);
		if (idx < n_before) return text_store[idx];
		return text_store[STORE_CAP - n_after + (idx - n_before)];
	endfunction

	// Offer one request, hold it until taken, then predict its response
	task automatic send_edit(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
			input logic [CHAR_W-1:0] rep, input logic [CNT_W-1:0] pos);
		while (!steady_flow && $urandom_range(99) < 35) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.operation   <= op;
		req_ch.character   <= ch;
		req_ch.replacement <= rep;
		req_ch.position    <= pos;
		do @(posedge clk); while (!req_ch.ready);
		pending_views.push_back(apply_edit(op, ch, rep, pos));
		requests_sent++;
		status_seen[pending_views[$].status]++;
		if (n_before + n_after > longest_text) longest_text = n_before + n_after;
	endtask

	// Empty-side errors, moves at and beyond the ends, replace, spare codes
	task automatic test_edges_directed();
		send_edit(OP_BACKSPACE, 8'h00, 8'h00, 9'd0);
		send_edit(OP_DELETE, 8'h00, 8'h00, 9'd0);
		send_edit(OP_MOVE, 8'h00, 8'h00, 9'd0);
		send_edit(OP_MOVE, 8'h00, 8'h00, 9'd1);
		send_edit(OP_MOVE, 8'hFF, 8'hFF, CNT_W'(POS_MAX));
		send_edit(OP_REPLACE, 8'h00, 8'hFF, 9'd0);
		for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++)
			send_edit(OP_W'(op), 8'hFF, 8'hFF, CNT_W'(POS_MAX));
		send_edit(OP_INSERT, 8'h00, 8'h00, 9'd0);
		send_edit(OP_INSERT, 8'hFF, 8'h00, 9'd0);
		send_edit(OP_INSERT, 8'hA5, 8'h00, 9'd0);
		send_edit(OP_INSERT, 8'h5A, 8'h00, 9'd0);
		send_edit(OP_MOVE, 8'h00, 8'h00, 9'd0);
		send_edit(OP_MOVE, 8'h00, 8'h00, 9'd2);
		send_edit(OP_MOVE, 8'h00, 8'h00, 9'd2);
		send_edit(OP_MOVE, 8'h00, 8'h00, 9'd4);
		send_edit(OP_MOVE, 8'h00, 8'h00, 9'd5);
		send_edit(OP_MOVE, 8'h00, 8'h00, 9'd1);
		send_edit(OP_REPLACE, 8'hFF, 8'h00, 9'd0);
		send_edit(OP_REPLACE, 8'h5A, 8'hA5, 9'd0);
		send_edit(OP_DELETE, 8'h00, 8'h00, 9'd0);
		send_edit(OP_BACKSPACE, 8'h00, 8'h00, 9'd0);
	endtask

	// Fill the store to capacity without idling, then probe the full and end cases
	task automatic test_full_store();
		steady_flow = 1'b1;
		while (n_before + n_after < STORE_CAP) begin
			if ($urandom_range(9) == 0)
				send_edit(OP_MOVE, 8'h00, 8'h00, CNT_W'($urandom_range(n_before + n_after)));
			else
				send_edit(OP_INSERT, 8'($urandom_range(255)), 8'h00, 9'd0);
		end
		repeat (3) send_edit(OP_INSERT, 8'($urandom_range(255)), 8'h00, 9'd0);
		send_edit(OP_MOVE, 8'h00, 8'h00, 9'd0);
		send_edit(OP_BACKSPACE, 8'h00, 8'h00, 9'd0);
		send_edit(OP_MOVE, 8'h00, 8'h00, CNT_W'(STORE_CAP));
		send_edit(OP_MOVE, 8'h00, 8'h00, CNT_W'(STORE_CAP + 1));
		send_edit(OP_DELETE, 8'h00, 8'h00, 9'd0);
		send_edit(OP_REPLACE, pick_text_char(), 8'($urandom_range(255)), 9'd0);
		send_edit(OP_BACKSPACE, 8'h00, 8'h00, 9'd0);
		send_edit(OP_INSERT, 8'h7E, 8'h00, 9'd0);
		send_edit(OP_INSERT, 8'h81, 8'h00, 9'd0);
		send_edit(OP_MOVE, 8'h00, 8'h00, 9'd0);
		send_edit(OP_DELETE, 8'h00, 8'h00, 9'd0);
		send_edit(OP_INSERT, 8'h3C, 8'h00, 9'd0);
		steady_flow = 1'b0;
	endtask

	// Random editing; the insert and removal weights steer the text length
	task automatic test_random_edits(input int n_requests, input int ins_pct, input int rem_pct);
		int                r;
		int                pick;
		int                len;
		int                move_top;
		logic [CHAR_W-1:0] ch;
		move_top = ins_pct + rem_pct + (96 - ins_pct - rem_pct) * 55 / 100;
		repeat (n_requests) begin
			r = $urandom_range(99);
			len = n_before + n_after;
			if (r < ins_pct) begin
				send_edit(OP_INSERT, 8'($urandom_range(255)), 8'($urandom_range(255)),
					CNT_W'($urandom_range(POS_MAX)));
			end else if (r < ins_pct + rem_pct / 2) begin
				send_edit(OP_DELETE, 8'($urandom_range(255)), 8'($urandom_range(255)),
					CNT_W'($urandom_range(POS_MAX)));
			end else if (r < ins_pct + rem_pct) begin
				send_edit(OP_BACKSPACE, 8'($urandom_range(255)), 8'($urandom_range(255)),
					CNT_W'($urandom_range(POS_MAX)));
			end else if (r < move_top) begin
				pick = $urandom_range(99);
				if (pick < 85) pick = $urandom_range(len);
				else if (pick < 95) pick = $urandom_range(POS_MAX, len + 1);
				else pick = $urandom_range(1) ? len : 0;
				send_edit(OP_MOVE, 8'($urandom_range(255)), 8'($urandom_range(255)),
					CNT_W'(pick));
			end else if (r < 96) begin
				ch = (len != 0 && $urandom_range(9) < 7) ? pick_text_char()
					: 8'($urandom_range(255));
				send_edit(OP_REPLACE, ch, 8'($urandom_range(255)),
					CNT_W'($urandom_range(POS_MAX)));
			end else begin
				send_edit(OP_W'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST)),
					8'($urandom_range(255)), 8'($urandom_range(255)),
					CNT_W'($urandom_range(POS_MAX)));
			end
		end
	endtask

	// Stimulus: reset once, then each test in turn
	initial begin
		arst_n             = 1'b0;
		req_ch.valid       = 1'b0;
		req_ch.operation   = '0;
		req_ch.character   = '0;
		req_ch.replacement = '0;
		req_ch.position    = '0;
		steady_flow        = 1'b0;
		fail_count         = 0;
		requests_sent      = 0;
		longest_text       = 0;
		n_before           = 0;
		n_after            = 0;
		foreach (status_seen[i]) status_seen[i] = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_edges_directed();
		test_full_store();
		test_random_edits(820, 10, 34);
		test_random_edits(820, 45, 24);
		req_ch.valid <= 1'b0;

		while (pending_views.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d editing requests, longest text %0d of %0d characters",
			requests_sent, longest_text, STORE_CAP);
		$display("Statuses seen: ok %0d, side empty %0d, beyond text %0d, store full %0d",
			status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_BEYOND],
			status_seen[ST_FULL]);
		if (fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// Response side: stall at random, compare each taken response with the oldest prediction
	initial begin
		cursor_view_t exp_view;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
				if (pending_views.size() == 0) begin
					$error("response with no request outstanding");
					fail_count++;
				end else begin
					exp_view = pending_views.pop_front();
					if (rsp_ch.status !== exp_view.status) begin
						$error("status: expected %0d, got %0d", exp_view.status, rsp_ch.status);
						fail_count++;
					end
					if (rsp_ch.count_before_cursor !== exp_view.n_before) begin
						$error("count_before_cursor: expected %0d, got %0d",
							exp_view.n_before, rsp_ch.count_before_cursor);
						fail_count++;
					end
					if (rsp_ch.count_after_cursor !== exp_view.n_after) begin
						$error("count_after_cursor: expected %0d, got %0d",
							exp_view.n_after, rsp_ch.count_after_cursor);
						fail_count++;
					end
					// The top of an empty side reads as zero
					if (rsp_ch.char_before_cursor !== exp_view.ch_before) begin
						$error("char_before_cursor: expected %0h, got %0h",
							exp_view.ch_before, rsp_ch.char_before_cursor);
						fail_count++;
					end
					if (rsp_ch.char_after_cursor !== exp_view.ch_after) begin
						$error("char_after_cursor: expected %0h, got %0h",
							exp_view.ch_after, rsp_ch.char_after_cursor);
						fail_count++;
					end
				end
			end
			rsp_ch.ready <= steady_flow || ($urandom_range(99) >= 35);
		end
	end

	// Guard against a hung run
	initial begin
		#30ms;
		$display("Regression FAIL");
		$finish;
	end

endmodule
`default_nettype wire
